[hw/rtl/chd_pkg.sv]
// Package for the cartridge header decoder: codes, constants, result type and
// the type-byte and RAM-size decode functions. No dependencies.

package chd_pkg;

  // Header address map (9-bit addresses)
  localparam logic [8:0] LogoHashFirst = 9'h11C;
  localparam logic [8:0] LogoHashLast  = 9'h133;
  localparam logic [8:0] SumFirst      = 9'h134;
  localparam logic [8:0] SumLast       = 9'h14C;
  localparam logic [8:0] AddrColour    = 9'h143;
  localparam logic [8:0] AddrType      = 9'h147;
  localparam logic [8:0] AddrRomCode   = 9'h148;
  localparam logic [8:0] AddrRamCode   = 9'h149;
  localparam logic [8:0] AddrChecksum  = 9'h14D;

  localparam logic [31:0] FnvBasis     = 32'h811C_9DC5;
  localparam logic [31:0] FnvPrime     = 32'h0100_0193;
  localparam logic [31:0] LogoHashGood = 32'h9FD2_0031;

  localparam logic [7:0] ColourFlagOnly = 8'hC0;
  localparam logic [7:0] ColourFlagBoth = 8'h80;
  localparam logic [7:0] RomCodeMax     = 8'd8;
  localparam logic [7:0] RamCodeMax     = 8'd5;
  localparam logic [17:0] Mbc2RamBytes  = 18'h200;

  typedef enum logic [1:0] {
    CFG_CONSOLE_SELECT   = 2'd0,
    CFG_MULTICART_ENABLE = 2'd1,
    CFG_LOADED_ROM_BANKS = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SEL_BY_HEADER = 2'd0,
    SEL_MONO      = 2'd1,
    SEL_COLOUR    = 2'd2
  } console_sel_e;

  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_MBC1      = 3'd1,
    KIND_MBC1_MULT = 3'd2,
    KIND_MBC2      = 3'd3,
    KIND_MBC3      = 3'd4,
    KIND_MBC5      = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_BAD_RAM     = 3'd1,
    STAT_UNSUPPORTED = 3'd2,
    STAT_UNKNOWN     = 3'd3,
    STAT_BAD_ROM     = 3'd4
  } status_e;

  typedef struct packed {
    status_e status;
    kind_e   kind;
    logic    ram;
    logic    clk;
    logic    rum;
  } type_dec_t;

  // Cartridge type byte to controller kind and features
  function automatic type_dec_t decode_type(input logic [7:0] t);
    type_dec_t d;
    d = '{status: STAT_OK, kind: KIND_NONE, ram: 1'b0, clk: 1'b0, rum: 1'b0};
    case (t)
      8'h00: ;
      8'h01: d.kind = KIND_MBC1;
      8'h02, 8'h03: begin
        d.kind = KIND_MBC1;
        d.ram  = 1'b1;
      end
      8'h05: d.kind = KIND_MBC2;
      8'h06: begin
        d.kind = KIND_MBC2;
        d.ram  = 1'b1;
      end
      8'h08, 8'h09: d.ram = 1'b1;
      8'h0F: begin
        d.kind = KIND_MBC3;
        d.clk  = 1'b1;
      end
      8'h10: begin
        d.kind = KIND_MBC3;
        d.ram  = 1'b1;
        d.clk  = 1'b1;
      end
      8'h11: d.kind = KIND_MBC3;
      8'h12, 8'h13: begin
        d.kind = KIND_MBC3;
        d.ram  = 1'b1;
      end
      8'h19: d.kind = KIND_MBC5;
      8'h1A, 8'h1B: begin
        d.kind = KIND_MBC5;
        d.ram  = 1'b1;
      end
      8'h1C: begin
        d.kind = KIND_MBC5;
        d.rum  = 1'b1;
      end
      8'h1D, 8'h1E: begin
        d.kind = KIND_MBC5;
        d.ram  = 1'b1;
        d.rum  = 1'b1;
      end
      8'h0B, 8'h0C, 8'h0D, 8'h20, 8'h22, 8'hFC, 8'hFD, 8'hFE, 8'hFF:
        d.status = STAT_UNSUPPORTED;
      default: d.status = STAT_UNKNOWN;
    endcase
    return d;
  endfunction

  // RAM size code to bytes; codes above five give zero here
  function automatic logic [17:0] ram_code_to_bytes(input logic [2:0] code);
    logic [17:0] r;
    case (code)
      3'd1:    r = 18'h0_0800;
      3'd2:    r = 18'h0_2000;
      3'd3:    r = 18'h0_8000;
      3'd4:    r = 18'h2_0000;
      3'd5:    r = 18'h1_0000;
      default: r = 18'h0_0000;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/cartridge_header_decoder.sv]
// Cartridge header decoder top level: hashes, checksums and decodes a header
// byte stream into one result per header. Depends on chd_pkg.
//
// Channel  | Direction | Handshake                | Moves
// ---------+-----------+--------------------------+--------------------------------
// in       | input     | in_valid_i / in_stall_o  | one header byte and its address
// out      | output    | out_valid_o / out_stall_i| one decoded header result
// cfg      | input     | cfg_we_i                 | one register write, no wait
//
// Cycles: one byte transfer per cycle, unless a final byte is stalled; a byte
// is held in the input register, where hash, sum and captures update and, on the
// final byte, the header is decoded into the result register.
// Result: the result register loads when the final byte leaves the input
// register, and the result is offered on out_valid_o until it transfers.
// Reset: clears pipeline valids, config registers and header state (hash to
// the FNV basis, sum and captures to zero).
// Stalls: only a final byte waits, and only while the result register is held.

module cartridge_header_decoder
  import chd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [9:0]            cfg_data_i,
  // byte stream
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [8:0]            byte_address_i,
  input  logic [7:0]            byte_value_i,
  input  logic                  final_byte_i,
  // result
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  console_is_colour_o,
  output logic                  colour_mode_o,
  output logic [9:0]            rom_bank_count_o,
  output logic [17:0]           ram_bytes_o,
  output logic [2:0]            controller_kind_o,
  output logic                  has_ext_ram_o,
  output logic                  has_clock_o,
  output logic                  has_rumble_o,
  output logic [2:0]            status_o,
  output logic                  size_mismatch_o,
  output logic                  logo_mismatch_o,
  output logic                  checksum_mismatch_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0] console_select_q;
  logic       multicart_enable_q;
  logic [9:0] loaded_rom_banks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      console_select_q   <= SEL_BY_HEADER;
      multicart_enable_q <= 1'b0;
      loaded_rom_banks_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CONSOLE_SELECT:   console_select_q   <= cfg_data_i[1:0];
        CFG_MULTICART_ENABLE: multicart_enable_q <= cfg_data_i[0];
        CFG_LOADED_ROM_BANKS: loaded_rom_banks_q <= cfg_data_i;
        default: ; // unmapped index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic       s1_valid_q;
  logic [8:0] s1_addr_q;
  logic [7:0] s1_value_q;
  logic       s1_final_q;

  logic out_free;   // result register can take a new result this cycle
  logic s1_go;      // byte in the input register is consumed this cycle
  logic in_xfer;

  assign out_free   = !out_valid_o || !out_stall_i;
  // Non-final bytes only touch header state, so they never wait.
  assign s1_go      = s1_valid_q && (!s1_final_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_addr_q  <= byte_address_i;
      s1_value_q <= byte_value_i;
      s1_final_q <= final_byte_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Header state: running hash, running checksum and captured bytes
  // ---------------------------------------------------------------------------
  logic [31:0] logo_hash_q, logo_hash_d;
  logic [7:0]  running_sum_q, running_sum_d;
  logic [7:0]  colour_flag_q, colour_flag_d;
  logic [7:0]  type_byte_q, type_byte_d;
  logic [7:0]  rom_code_q, rom_code_d;
  logic [7:0]  ram_code_q, ram_code_d;
  logic [7:0]  stored_sum_q, stored_sum_d;

  logic        in_hash_range, in_sum_range;
  logic [31:0] hash_mix;

  assign in_hash_range = (s1_addr_q >= LogoHashFirst) && (s1_addr_q <= LogoHashLast);
  assign in_sum_range  = (s1_addr_q >= SumFirst) && (s1_addr_q <= SumLast);
  assign hash_mix      = logo_hash_q ^ {24'h0, s1_value_q};

  // Fold the byte held in the input register into the header state.
  always_comb begin
    logo_hash_d   = logo_hash_q;
    running_sum_d = running_sum_q;
    colour_flag_d = colour_flag_q;
    type_byte_d   = type_byte_q;
    rom_code_d    = rom_code_q;
    ram_code_d    = ram_code_q;
    stored_sum_d  = stored_sum_q;
    // FNV-1a step: multiply by a constant, i.e. a short shift-add tree
    if (in_hash_range) begin
      logo_hash_d = 32'(hash_mix * FnvPrime);
    end
    if (in_sum_range) begin
      running_sum_d = running_sum_q - 8'(s1_value_q + 8'd1);
    end
    case (s1_addr_q)
      AddrColour:   colour_flag_d = s1_value_q;
      AddrType:     type_byte_d   = s1_value_q;
      AddrRomCode:  rom_code_d    = s1_value_q;
      AddrRamCode:  ram_code_d    = s1_value_q;
      AddrChecksum: stored_sum_d  = s1_value_q;
      default: ;
    endcase
  end

  // Advance on every consumed byte; the final byte returns state to reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      logo_hash_q   <= FnvBasis;
      running_sum_q <= '0;
      colour_flag_q <= '0;
      type_byte_q   <= '0;
      rom_code_q    <= '0;
      ram_code_q    <= '0;
      stored_sum_q  <= '0;
    end else if (s1_go) begin
      if (s1_final_q) begin
        logo_hash_q   <= FnvBasis;
        running_sum_q <= '0;
        colour_flag_q <= '0;
        type_byte_q   <= '0;
        rom_code_q    <= '0;
        ram_code_q    <= '0;
        stored_sum_q  <= '0;
      end else begin
        logo_hash_q   <= logo_hash_d;
        running_sum_q <= running_sum_d;
        colour_flag_q <= colour_flag_d;
        type_byte_q   <= type_byte_d;
        rom_code_q    <= rom_code_d;
        ram_code_q    <= ram_code_d;
        stored_sum_q  <= stored_sum_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Header decode, from the state including the final byte
  // ---------------------------------------------------------------------------
  logic        flag_colour;
  logic        colour;
  logic        mode;
  type_dec_t   tdec;
  status_e     status;
  logic        ok;
  kind_e       kind;
  logic [9:0]  banks;
  logic [17:0] ramb;

  assign flag_colour = (colour_flag_d == ColourFlagOnly) || (colour_flag_d == ColourFlagBoth);

  always_comb begin
    case (console_sel_e'(console_select_q))
      SEL_BY_HEADER: colour = flag_colour;
      SEL_MONO:      colour = 1'b0;
      SEL_COLOUR:    colour = 1'b1;
      default:       colour = 1'b1; // code three acts as colour
    endcase
  end

  assign mode = colour && flag_colour;
  assign tdec = decode_type(type_byte_d);

  // ROM code error ranks above RAM code error, which ranks above the type
  always_comb begin
    if (rom_code_d > RomCodeMax) begin
      status = STAT_BAD_ROM;
    end else if (ram_code_d > RamCodeMax) begin
      status = STAT_BAD_RAM;
    end else begin
      status = tdec.status;
    end
  end

  assign ok = (status == STAT_OK);

  always_comb begin
    kind = tdec.kind;
    if (kind == KIND_MBC1 && multicart_enable_q) begin
      kind = KIND_MBC1_MULT;
    end
    ramb = ram_code_to_bytes(ram_code_d[2:0]);
    if (tdec.kind == KIND_MBC2 && tdec.ram) begin
      ramb = Mbc2RamBytes;
    end
  end

  // Code is at most eight when status is ok, so the shift stays within 10 bits
  assign banks = 10'd2 << rom_code_d[3:0];

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic        res_load;
  logic        out_valid_q;
  logic        colour_q, mode_q;
  logic [9:0]  banks_q;
  logic [17:0] ramb_q;
  kind_e       kind_q;
  logic        ram_q, clk_q, rum_q;
  status_e     status_q;
  logic        szm_q, logom_q, csm_q;

  assign res_load = s1_go && s1_final_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold while stalled; on error zero everything but console, mode and status.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      colour_q <= colour;
      mode_q   <= mode;
      status_q <= status;
      banks_q  <= ok ? banks : '0;
      ramb_q   <= ok ? ramb : '0;
      kind_q   <= ok ? kind : KIND_NONE;
      ram_q    <= ok && tdec.ram;
      clk_q    <= ok && tdec.clk;
      rum_q    <= ok && tdec.rum;
      szm_q    <= ok && (loaded_rom_banks_q != banks);
      logom_q  <= ok && !colour && (logo_hash_d != LogoHashGood);
      csm_q    <= ok && (running_sum_d != stored_sum_d);
    end
  end

  assign out_valid_o         = out_valid_q;
  assign console_is_colour_o = colour_q;
  assign colour_mode_o       = mode_q;
  assign rom_bank_count_o    = banks_q;
  assign ram_bytes_o         = ramb_q;
  assign controller_kind_o   = kind_q;
  assign has_ext_ram_o       = ram_q;
  assign has_clock_o         = clk_q;
  assign has_rumble_o        = rum_q;
  assign status_o            = status_q;
  assign size_mismatch_o     = szm_q;
  assign logo_mismatch_o     = logom_q;
  assign checksum_mismatch_o = csm_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Only a final byte facing a held result may stall the byte stream.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_final_q && out_valid_o && out_stall_i))
    else $error("byte stream stalled without a held result");

  // A consumed final byte leaves the header state at its reset values.
  a_state_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> (logo_hash_q == FnvBasis && running_sum_q == 8'd0 && type_byte_q == 8'd0))
    else $error("header state not cleared after final byte");

  // An error result carries no geometry, controller or warnings.
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STAT_OK) |->
      (rom_bank_count_o == 10'd0 && ram_bytes_o == 18'd0 &&
       controller_kind_o == KIND_NONE && !size_mismatch_o &&
       !logo_mismatch_o && !checksum_mismatch_o))
    else $error("error result carries decoded fields");

  // A good result has a single power-of-two bank count.
  a_banks_pow2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STAT_OK) |-> $onehot(rom_bank_count_o))
    else $error("bank count not a power of two");

  // Color game mode requires the color console; the logo is checked only on mono.
  a_mode_console: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((!colour_mode_o || console_is_colour_o) &&
                     (!logo_mismatch_o || !console_is_colour_o)))
    else $error("mode or logo flag inconsistent with console");

endmodule
